@@ design/bfc_pkg.sv @@
package bfc_pkg;

   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CAP_W     = 5;
   localparam int FILL_W    = 5;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLOSE = 2'd2,
      CMD_DRAIN = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_AGAIN = 2'd1,
      ST_END   = 2'd2
   } status_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     addr;
      logic [WORD_BITS-1:0] data;
   } slot_wr_type;

   typedef struct packed {
      status_type           status;
      logic [WORD_BITS-1:0] data;
      logic [CNT_W-1:0]     fill;
   } result_type;

endpackage

@@ design/bfc_slots.sv @@
module bfc_slots #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old contents on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bfc_ctrl.sv @@
module bfc_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [bfc_pkg::CAP_W-1:0]       csr_wr_data,
   input  logic                            fire,
   input  bfc_pkg::cmd_type                cmd,
   input  logic [bfc_pkg::WORD_BITS-1:0]   data_in,
   input  logic [bfc_pkg::WORD_BITS-1:0]   rd_data,
   output logic [bfc_pkg::IDX_W-1:0]       rd_addr,
   output bfc_pkg::slot_wr_type            wr,
   output bfc_pkg::result_type             result
);

   logic [bfc_pkg::CNT_W-1:0] cap_ff,   cap_in;
   logic [bfc_pkg::IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [bfc_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [bfc_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      closed_ff, closed_in;
   logic                      byp_hit_ff, byp_hit_in;
   logic [bfc_pkg::WORD_BITS-1:0] byp_data_ff;
   logic [bfc_pkg::WORD_BITS-1:0] rd_word;
   logic                      full;
   logic                      empty;
   logic                      push_ok;

   // step a pointer, wrapping at the capacity
   function automatic logic [bfc_pkg::IDX_W-1:0] step_idx(
      input logic [bfc_pkg::IDX_W-1:0] idx,
      input logic [bfc_pkg::CNT_W-1:0] cap
   );
      logic [bfc_pkg::CNT_W:0] nxt;
      nxt = (bfc_pkg::CNT_W+1)'(idx) + 1'b1;
      if (nxt >= (bfc_pkg::CNT_W+1)'(cap)) begin
         return '0;
      end
      return nxt[bfc_pkg::IDX_W-1:0];
   endfunction

   // 0 acts as 1, anything above the depth as the depth
   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            cap_in = bfc_pkg::CNT_W'(1);
         end else if (int'(csr_wr_data) > bfc_pkg::DEPTH) begin
            cap_in = bfc_pkg::CNT_W'(bfc_pkg::DEPTH);
         end else begin
            cap_in = bfc_pkg::CNT_W'(csr_wr_data);
         end
      end
   end

   assign full    = (count_ff >= cap_ff);
   assign empty   = (count_ff == '0);

   // slot read runs one update ahead so the word is ready for the next command
   assign rd_addr = fire ? rd_idx_in : rd_idx_ff;

   // a push landing on the prefetched slot is forwarded
   assign byp_hit_in = wr.en && (wr.addr == rd_addr);
   assign rd_word    = byp_hit_ff ? byp_data_ff : rd_data;

   always_comb begin
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      count_in      = count_ff;
      closed_in     = closed_ff;
      push_ok       = 1'b0;
      result.status = bfc_pkg::ST_OK;
      result.data   = '0;
      unique case (cmd)
         bfc_pkg::CMD_PUSH: begin
            if (closed_ff) begin
               result.status = bfc_pkg::ST_END;
            end else if (full) begin
               result.status = bfc_pkg::ST_AGAIN;
            end else begin
               push_ok   = 1'b1;
               wr_idx_in = step_idx(wr_idx_ff, cap_ff);
               count_in  = count_ff + 1'b1;
            end
         end
         bfc_pkg::CMD_POP: begin
            if (closed_ff) begin
               result.status = bfc_pkg::ST_END;
            end else if (empty) begin
               result.status = bfc_pkg::ST_AGAIN;
            end else begin
               result.data = rd_word;
               rd_idx_in   = step_idx(rd_idx_ff, cap_ff);
               count_in    = count_ff - 1'b1;
            end
         end
         bfc_pkg::CMD_CLOSE: begin
            closed_in = 1'b1;
         end
         bfc_pkg::CMD_DRAIN: begin
            if (!empty) begin
               result.data = rd_word;
               rd_idx_in   = step_idx(rd_idx_ff, cap_ff);
               count_in    = count_ff - 1'b1;
            end else if (closed_ff) begin
               result.status = bfc_pkg::ST_END;
            end else begin
               result.status = bfc_pkg::ST_AGAIN;
            end
         end
         default: begin
            result.status = bfc_pkg::ST_OK;
         end
      endcase
      result.fill = count_in;
   end

   assign wr.en   = fire && push_ok;
   assign wr.addr = wr_idx_ff;
   assign wr.data = data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= bfc_pkg::CNT_W'(bfc_pkg::DEPTH);
         wr_idx_ff  <= '0;
         rd_idx_ff  <= '0;
         count_ff   <= '0;
         closed_ff  <= 1'b0;
         byp_hit_ff <= 1'b0;
      end else begin
         cap_ff     <= cap_in;
         byp_hit_ff <= byp_hit_in;
         if (fire) begin
            wr_idx_ff <= wr_idx_in;
            rd_idx_ff <= rd_idx_in;
            count_ff  <= count_in;
            closed_ff <= closed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         byp_data_ff <= wr.data;
      end
   end

endmodule

@@ design/bounded_fifo_with_close.sv @@
// Bounded FIFO of 32-bit words with a close flag. Each request carries one
// command in req_tuser (push, pop, close, clearing pop) and each request
// yields exactly one response with a status in rsp_tuser (ok, again, end),
// the popped word (zero unless a pop succeeded) and the fill count after the
// command. Push on a full queue or pop on an empty one answers "again" at
// once instead of waiting. The capacity register (csr_wr_data, 1..16; 0 acts
// as 1, larger values as 16) sets where the pointers wrap; write it only
// while the block is idle. A request is registered in the input register, then
// resolved against the pointers, count and slot array into the response register:
// one request per cycle sustained while rsp_tready stays high, as the pointers and
// count take a single update per accepted request.
module bounded_fifo_with_close (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] data_in
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] data_out, [36:32] fill_count, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // capacity register
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   // input register
   logic                              in_valid_ff, in_valid_in;
   bfc_pkg::cmd_type                  in_cmd_ff;
   logic [bfc_pkg::WORD_BITS-1:0]     in_data_ff;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   bfc_pkg::result_type               rsp_ff;

   logic                              req_fire;
   logic                              advance;
   logic [bfc_pkg::IDX_W-1:0]         rd_addr;
   logic [bfc_pkg::WORD_BITS-1:0]     rd_data;
   bfc_pkg::slot_wr_type              slot_wr;
   bfc_pkg::result_type               result;

   // held request moves on when the response register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff  <= bfc_pkg::cmd_type'(req_tuser);
         in_data_ff <= req_tdata[bfc_pkg::WORD_BITS-1:0];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   // pointers, count, closed flag and capacity; decides each command
   bfc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (advance),
      .cmd         (in_cmd_ff),
      .data_in     (in_data_ff),
      .rd_data     (rd_data),
      .rd_addr     (rd_addr),
      .wr          (slot_wr),
      .result      (result)
   );

   // word storage, registered read fetched ahead at the next read pointer
   bfc_slots #(
      .WIDTH (bfc_pkg::WORD_BITS),
      .DEPTH (bfc_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (slot_wr.en),
      .wr_addr (slot_wr.addr),
      .wr_data (slot_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tuser        = rsp_ff.status;
   assign rsp_tdata[31:0]  = rsp_ff.data;
   assign rsp_tdata[36:32] = bfc_pkg::FILL_W'(rsp_ff.fill);
   assign rsp_tdata[39:37] = '0;

endmodule

@@ tb/sv/tb.sv @@
module tb;

   // one command as handed to the request channel
   typedef struct {
      bfc_pkg::cmd_type cmd;
      logic [31:0]      word;
   } request_type;

   // what the queue should answer for one command
   typedef struct {
      bfc_pkg::status_type        status;
      logic [31:0]                word;
      logic [bfc_pkg::FILL_W-1:0] fill;
   } response_type;

   localparam int QUIET_LIMIT = 3000;   // cycles without any handshake before giving up
   localparam int MAX_PRINTS  = 40;

   // every input starts at a known value
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = bfc_pkg::CMD_PUSH;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [4:0]  csr_wr_data = '0;

   bounded_fifo_with_close uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   request_type  pending_requests[$];    // filled by the sequence, drained by the driver
   response_type awaited_responses[$];   // predicted answers, oldest first

   int error_count   = 0;
   int quiet_cycles  = 0;
   int cap_writes    = 0;
   int cmd_seen[4]   = '{default: 0};
   int status_seen[4] = '{default: 0};

   // ------------------------------------------------------------------
   // queue model: its own copy of slots, pointers, fill and close flag
   // ------------------------------------------------------------------
   logic [31:0]               model_slots[bfc_pkg::DEPTH];
   logic [bfc_pkg::IDX_W-1:0] wr_ptr;
   logic [bfc_pkg::IDX_W-1:0] rd_ptr;
   logic [4:0]                held;
   logic                      is_closed;
   logic [bfc_pkg::CAP_W-1:0] cap_reg;

   // 0 behaves as one entry, anything past the array as the whole array
   function automatic logic [4:0] usable_depth();
      if (cap_reg == 0)
         return 5'd1;
      if (cap_reg > bfc_pkg::DEPTH)
         return 5'(bfc_pkg::DEPTH);
      return cap_reg;
   endfunction

   // a pointer wraps once it reaches the usable depth, even if it was already past it
   function automatic logic [bfc_pkg::IDX_W-1:0] wrap_next(logic [bfc_pkg::IDX_W-1:0] ptr);
      logic [4:0] nxt;
      nxt = 5'(ptr) + 5'd1;
      return (nxt >= usable_depth()) ? '0 : nxt[bfc_pkg::IDX_W-1:0];
   endfunction

   function automatic logic [31:0] take_oldest();
      logic [31:0] w;
      w      = model_slots[rd_ptr];
      rd_ptr = wrap_next(rd_ptr);
      held   = held - 5'd1;
      return w;
   endfunction

   function automatic response_type resolve_request(bfc_pkg::cmd_type c, logic [31:0] w);
      response_type r;
      r.status = bfc_pkg::ST_OK;
      r.word   = '0;
      case (c)
         bfc_pkg::CMD_PUSH: begin
            if (is_closed)
               r.status = bfc_pkg::ST_END;
            else if (held >= usable_depth())
               r.status = bfc_pkg::ST_AGAIN;   // full, or still above a capacity that shrank
            else begin
               model_slots[wr_ptr] = w;
               wr_ptr = wrap_next(wr_ptr);
               held   = held + 5'd1;
            end
         end
         bfc_pkg::CMD_POP: begin
            if (is_closed)
               r.status = bfc_pkg::ST_END;     // closed wins even with words held
            else if (held == 0)
               r.status = bfc_pkg::ST_AGAIN;
            else
               r.word = take_oldest();
         end
         bfc_pkg::CMD_CLOSE: is_closed = 1'b1;  // sticky, closing twice is fine
         default: begin
            // clearing pop ignores the flag while words remain
            if (held != 0)
               r.word = take_oldest();
            else
               r.status = is_closed ? bfc_pkg::ST_END : bfc_pkg::ST_AGAIN;
         end
      endcase
      r.fill = held;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // request driver: bursts of random length separated by random gaps
   // ------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : request_driver
      request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            nxt = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.word;
            req_tuser  <= nxt.cmd;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 30);
               // about a quarter of the bursts run straight into the next one
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // response stall pattern: four modes in turn
   // always ready, alternating, coin flip, mostly stalled
   // ------------------------------------------------------------------
   logic [7:0] stall_phase = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= '0;
      end else begin
         stall_phase <= stall_phase + 8'd1;
         case (stall_phase[7:6])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= stall_phase[0];
            2'd2: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 99) < 15);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // monitor: track capacity writes, predict on each request, check each response
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      response_type want;
      if (reset) begin
         wr_ptr    = '0;
         rd_ptr    = '0;
         held      = '0;
         is_closed = 1'b0;
         cap_reg   = 5'd16;
      end else begin
         if (csr_wr_en)
            cap_reg = csr_wr_data;
         // a response always belongs to an earlier request, so check first
         if (rsp_tvalid && rsp_tready) begin
            status_seen[rsp_tuser]++;
            if (awaited_responses.size() == 0) begin
               report_mismatch("response with nothing outstanding", rsp_tdata, '0);
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 40'(rsp_tuser), 40'(want.status));
               if (rsp_tdata[31:0] !== want.word)
                  report_mismatch("data_out", 40'(rsp_tdata[31:0]), 40'(want.word));
               if (rsp_tdata[36:32] !== want.fill)
                  report_mismatch("fill_count", 40'(rsp_tdata[36:32]), 40'(want.fill));
               if (rsp_tdata[39:37] !== 3'b000)
                  report_mismatch("tdata padding", 40'(rsp_tdata[39:37]), '0);
            end
         end
         if (req_tvalid && req_tready) begin
            cmd_seen[req_tuser]++;
            awaited_responses.push_back(
               resolve_request(bfc_pkg::cmd_type'(req_tuser), req_tdata));
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: too long with neither channel moving ends the run
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d requests queued, %0d awaited",
                     QUIET_LIMIT, pending_requests.size(), awaited_responses.size());
            $display("DONE: errors detected");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // sequence helpers
   // ------------------------------------------------------------------
   task automatic add_request(bfc_pkg::cmd_type c, logic [31:0] w);
      request_type r;
      r.cmd  = c;
      r.word = w;
      pending_requests.push_back(r);
   endtask

   // mostly random words, with the all-zero and all-one corners now and then
   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // settle on the falling edge so driver and monitor updates are all visible
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || awaited_responses.size() != 0);
   endtask

   // capacity only changes with nothing in flight; words held stay where they are
   task automatic write_capacity(logic [4:0] value);
      wait_until_drained();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_writes++;
   endtask

   // stretches that lean toward filling, balance, or emptying so full and empty both get hit
   task automatic run_mixed_phase(int n, bit with_close);
      int stretch;
      int push_pct;
      int roll;
      stretch  = 0;
      push_pct = 50;
      for (int i = 0; i < n; i++) begin
         if (stretch == 0) begin
            stretch = $urandom_range(4, 24);
            case ($urandom_range(0, 2))
               0: push_pct = 80;
               1: push_pct = 50;
               default: push_pct = 20;
            endcase
         end
         stretch--;
         roll = $urandom_range(0, 99);
         if (with_close && roll < 8)
            add_request(bfc_pkg::CMD_CLOSE, random_word());
         else if (roll < push_pct)
            add_request(bfc_pkg::CMD_PUSH, random_word());
         else if ($urandom_range(0, 9) < 7)
            add_request(bfc_pkg::CMD_POP, random_word());
         else
            add_request(bfc_pkg::CMD_DRAIN, random_word());
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_capacity(5'd16);

      // directed, queue open at full capacity: empty cases first
      add_request(bfc_pkg::CMD_POP, 32'h0000_0000);
      add_request(bfc_pkg::CMD_DRAIN, 32'hFFFF_FFFF);
      // fill every slot once so no later read can land on an unwritten entry
      add_request(bfc_pkg::CMD_PUSH, 32'h0000_0000);
      add_request(bfc_pkg::CMD_PUSH, 32'hFFFF_FFFF);
      add_request(bfc_pkg::CMD_PUSH, 32'h0000_0001);
      add_request(bfc_pkg::CMD_PUSH, 32'h8000_0000);
      add_request(bfc_pkg::CMD_PUSH, 32'hA5A5_A5A5);
      add_request(bfc_pkg::CMD_PUSH, 32'h5A5A_5A5A);
      for (int i = 0; i < 10; i++)
         add_request(bfc_pkg::CMD_PUSH, $urandom);
      // full: push reports again
      add_request(bfc_pkg::CMD_PUSH, 32'hDEAD_BEEF);
      add_request(bfc_pkg::CMD_POP, '0);
      add_request(bfc_pkg::CMD_DRAIN, '0);

      // random part with the queue open; capacity changes while words are held,
      // so pointers sit past the new limit and the fill can exceed it
      write_capacity(5'd0);      // behaves as one entry
      run_mixed_phase(75, 1'b0);
      write_capacity(5'd1);
      run_mixed_phase(75, 1'b0);
      write_capacity(5'd31);     // behaves as the full array
      run_mixed_phase(75, 1'b0);
      write_capacity(5'd2);
      run_mixed_phase(75, 1'b0);
      write_capacity(5'd17);
      run_mixed_phase(75, 1'b0);
      write_capacity(5'($urandom_range(3, 15)));
      run_mixed_phase(75, 1'b0);
      write_capacity(5'd16);
      run_mixed_phase(75, 1'b0);
      write_capacity(5'($urandom_range(0, 31)));
      run_mixed_phase(75, 1'b0);

      // closing is sticky and reset comes only once, so the closed cases go last
      write_capacity(5'd8);
      add_request(bfc_pkg::CMD_PUSH, random_word());
      add_request(bfc_pkg::CMD_PUSH, random_word());
      add_request(bfc_pkg::CMD_PUSH, random_word());
      add_request(bfc_pkg::CMD_POP, random_word());
      add_request(bfc_pkg::CMD_CLOSE, random_word());
      add_request(bfc_pkg::CMD_PUSH, random_word());     // end, nothing stored
      add_request(bfc_pkg::CMD_POP, random_word());      // end although words remain
      add_request(bfc_pkg::CMD_CLOSE, random_word());    // closing again still succeeds
      add_request(bfc_pkg::CMD_DRAIN, random_word());    // clearing pop still hands out words
      run_mixed_phase(50, 1'b1);
      // drain to empty, then clearing pop on a closed empty queue gives end
      for (int i = 0; i < 20; i++)
         add_request(bfc_pkg::CMD_DRAIN, random_word());

      wait_until_drained();
      repeat (10) @(posedge clock);

      $display("requests: %0d push, %0d pop, %0d close, %0d clearing pop, %0d capacity writes",
               cmd_seen[bfc_pkg::CMD_PUSH], cmd_seen[bfc_pkg::CMD_POP],
               cmd_seen[bfc_pkg::CMD_CLOSE], cmd_seen[bfc_pkg::CMD_DRAIN], cap_writes);
      $display("responses: %0d ok, %0d again, %0d end, %0d mismatches",
               status_seen[bfc_pkg::ST_OK], status_seen[bfc_pkg::ST_AGAIN],
               status_seen[bfc_pkg::ST_END], error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
